// ----- hw/rtl/smcp_pkg.sv -----
package smcp_pkg;

   localparam int MaxElementsDefault = 64;
   localparam logic [30:0] PenaltyBoundReset = 31'd163840;

   localparam logic [1:0] StatusNormal     = 2'd0;
   localparam logic [1:0] StatusInfeasible = 2'd1;
   localparam logic [1:0] StatusZeroSum    = 2'd2;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_ERR,
      ST_CORR,
      ST_DIVSTART,
      ST_DIVWAIT,
      ST_EMIT
   } state_type;

   // divider request/response bundle
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } div_rsp_type;

endpackage

// ----- hw/rtl/svm_multiplier_constraint_projection_top.sv -----
// SVM multiplier constraint projection.
// Input stream (req_): one transaction per element, multiplier and label, with
// req_tlast marking the final element. Elements are stored into two on-chip
// memories, one per cycle. Loading accepts one transaction per cycle while no result is pending.
// The transaction with tlast starts the projection and req_tready stays low
// until all results are taken. The projection makes three passes over the
// stored elements: error sum, correction sum, then emit. When the error is
// non-zero and the correction sum positive, each element waits on a 64-step
// bit-serial divider in the emit pass; otherwise it goes from read to emit.
// Result stream (rsp_): one transaction per element in index order, with
// rsp_tlast on the final one and the status in rsp_tuser. A stalled receiver
// holds the result register; the block waits on it, adding the stall cycles.
// csr_ writes the penalty bound; write only while idle.
// Reset is synchronous: the element count and penalty bound return to their
// reset values; the memory contents are not cleared.
module svm_multiplier_constraint_projection_top
   import smcp_pkg::*;
#(
   parameter int MAX_ELEMENTS = MaxElementsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] multiplier, [63:32] label
   input  logic        req_tlast,   // last_item
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] adjusted_value, [37:32] element_index, pad
   output logic        rsp_tlast,   // last_result
   output logic [1:0]  rsp_tuser,   // status
   input  logic        csr_wr_en,
   input  logic [30:0] csr_wr_data  // penalty_bound
);

   localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CW = $clog2(MAX_ELEMENTS + 1);
   localparam logic signed [63:0] S64Max = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] S64Min = 64'sh8000_0000_0000_0000;

   // element memories
   logic signed [31:0] mult_mem [MAX_ELEMENTS];
   logic signed [31:0] lab_mem  [MAX_ELEMENTS];
   logic signed [31:0] mult_rd_ff, lab_rd_ff;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [30:0]   bound_ff;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [31:0] err_ff, err_in;
   logic [63:0]   csum_ff, csum_in;
   logic [1:0]    status_ff, status_in;
   logic signed [63:0] prod_ff, prod_in;
   logic          prod_vld_ff, prod_vld_in;
   logic [CW-1:0] emit_ff, emit_in;
   logic signed [32:0] base_ff, base_in;
   logic          cneg_ff, cneg_in;
   logic [31:0]   cmag_ff, cmag_in;

   logic          ovld_ff, ovld_in;
   logic [31:0]   oval_ff, oval_in;
   logic [5:0]    oidx_ff, oidx_in;
   logic          olast_ff, olast_in;
   logic [1:0]    ostat_ff, ostat_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   smcp_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_tready = (state_ff == ST_LOAD) && !ovld_ff;
   assign wr_en = req_tvalid && req_tready && (count_ff < CW'(MAX_ELEMENTS));

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mult_mem[count_ff[AW-1:0]] <= req_tdata[31:0];
         lab_mem[count_ff[AW-1:0]]  <= req_tdata[63:32];
      end
      mult_rd_ff <= mult_mem[rd_addr];
      lab_rd_ff  <= lab_mem[rd_addr];
   end

   // per-element clamp and correction of the read data
   logic signed [32:0] clamped;
   logic signed [32:0] corr;
   logic               use_up;
   always_comb begin
      if (mult_rd_ff[31])
         clamped = '0;
      else if ($signed({1'b0, mult_rd_ff}) > $signed({2'b0, bound_ff}))
         clamped = $signed({2'b0, bound_ff});
      else
         clamped = $signed({1'b0, mult_rd_ff});
      use_up = ((err_ff > 0) == lab_rd_ff[31]);
      corr = use_up ? ($signed({2'b0, bound_ff}) - clamped) : -clamped;
   end

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (!a[63] && !b[63] && s[63]) return S64Max;
      if (a[63] && b[63] && !s[63]) return S64Min;
      return s;
   endfunction

   logic [32:0] cabs;
   logic [31:0] aerr;
   logic signed [64:0] sum_o;
   logic [32:0] qsel;
   assign cabs = corr[32] ? 33'(-corr) : 33'(corr);
   assign aerr = err_ff[31] ? 32'(-err_ff) : 32'(err_ff);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      rd_vld_in   = 1'b0;
      acc_in      = acc_ff;
      err_in      = err_ff;
      csum_in     = csum_ff;
      status_in   = status_ff;
      prod_in     = prod_ff;
      prod_vld_in = 1'b0;
      emit_in     = emit_ff;
      base_in     = base_ff;
      cneg_in     = cneg_ff;
      cmag_in     = cmag_ff;
      ovld_in     = ovld_ff && !rsp_tready;
      oval_in     = oval_ff;
      oidx_in     = oidx_ff;
      olast_in    = olast_ff;
      ostat_in    = ostat_ff;
      rd_addr     = idx_ff[AW-1:0];
      div_req.start    = 1'b0;
      div_req.dividend = 64'(aerr) * 64'(cmag_ff);
      div_req.divisor  = csum_ff;
      sum_o = '0;
      qsel  = '0;
      case (state_ff)
         ST_LOAD: begin
            if (req_tvalid && req_tready) begin
               if (wr_en) count_in = count_ff + CW'(1);
               if (req_tlast) begin
                  state_in = ST_ERR;
                  idx_in   = '0;
                  acc_in   = '0;
                  count_in = wr_en ? count_ff + CW'(1) : count_ff;
               end
            end
         end
         // error sum: read, multiply, accumulate
         ST_ERR: begin
            if (idx_ff < count_ff) begin
               rd_vld_in = 1'b1;
               idx_in = idx_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               prod_in = 64'(clamped) * 64'(lab_rd_ff);
               prod_vld_in = 1'b1;
            end
            if (prod_vld_ff) acc_in = sat_add(acc_ff, prod_ff >>> 16);
            if (idx_ff >= count_ff && !rd_vld_ff && !prod_vld_ff) begin
               if (acc_ff > 64'sd2147483647)       err_in = 32'sh7FFF_FFFF;
               else if (acc_ff < -64'sd2147483648) err_in = 32'sh8000_0000;
               else                                 err_in = acc_ff[31:0];
               idx_in = '0;
               csum_in = '0;
               state_in = ST_CORR;
            end
         end
         // correction magnitude sum
         ST_CORR: begin
            if (idx_ff < count_ff) begin
               rd_vld_in = 1'b1;
               idx_in = idx_ff + CW'(1);
            end
            if (rd_vld_ff) csum_in = csum_ff + 64'(cabs);
            if (idx_ff >= count_ff && !rd_vld_ff) begin
               if (err_ff == 0)
                  status_in = StatusNormal;
               else if (csum_ff == 0)
                  status_in = StatusZeroSum;
               else if (64'(aerr) > csum_ff)
                  status_in = StatusInfeasible;
               else
                  status_in = StatusNormal;
               idx_in  = '0;
               emit_in = '0;
               state_in = ST_DIVSTART;
            end
         end
         // per element: read, then divide if needed, then emit
         ST_DIVSTART: begin
            if (!rd_vld_ff) begin
               rd_vld_in = 1'b1;
            end else begin
               base_in = (status_ff == StatusInfeasible) ? '0 : clamped;
               cneg_in = corr[32];
               cmag_in = cabs[31:0];
               if (err_ff == 0 || status_ff == StatusZeroSum) begin
                  state_in = ST_EMIT;
                  if (status_ff == StatusZeroSum) base_in = '0;
               end else
                  state_in = ST_DIVWAIT;
            end
         end
         ST_DIVWAIT: begin
            div_req.start = (cmag_ff != 32'hFFFF_FFFF) && !div_rsp.done && !prod_vld_ff;
            prod_vld_in = 1'b1;
            if (div_rsp.done) begin
               qsel = div_rsp.quotient[32:0];
               sum_o = 65'(base_ff) + (cneg_ff ? -65'(qsel) : 65'(qsel));
               base_in = (sum_o > 65'sd2147483647) ? 33'sh0_7FFF_FFFF :
                         (sum_o < -65'sd2147483648) ? -33'sd2147483648 : 33'(sum_o);
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!ovld_ff || rsp_tready) begin
               ovld_in  = 1'b1;
               oval_in  = base_ff[31:0];
               oidx_in  = 6'(emit_ff);
               olast_in = (emit_ff + CW'(1) == count_ff);
               ostat_in = status_ff;
               emit_in  = emit_ff + CW'(1);
               idx_in   = emit_ff + CW'(1);
               if (emit_ff + CW'(1) == count_ff) begin
                  count_in = '0;
                  state_in = ST_LOAD;
               end else
                  state_in = ST_DIVSTART;
            end
         end
         default: state_in = ST_LOAD;
      endcase
      if (count_ff == '0 && state_ff == ST_ERR) begin
         state_in = ST_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      err_ff   <= err_in;
      csum_ff  <= csum_in;
      prod_ff  <= prod_in;
      emit_ff  <= emit_in;
      base_ff  <= base_in;
      cneg_ff  <= cneg_in;
      cmag_ff  <= cmag_in;
      oval_ff  <= oval_in;
      oidx_ff  <= oidx_in;
      olast_ff <= olast_in;
      ostat_ff <= ostat_in;
      if (reset) begin
         state_ff    <= ST_LOAD;
         count_ff    <= '0;
         idx_ff      <= '0;
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
         status_ff   <= StatusNormal;
         ovld_ff     <= 1'b0;
         bound_ff    <= PenaltyBoundReset;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         idx_ff      <= idx_in;
         rd_vld_ff   <= rd_vld_in;
         prod_vld_ff <= prod_vld_in;
         status_ff   <= status_in;
         ovld_ff     <= ovld_in;
         if (csr_wr_en) bound_ff <= csr_wr_data;
      end
   end

   assign rsp_tvalid = ovld_ff;
   assign rsp_tdata  = {2'b0, oidx_ff, oval_ff};
   assign rsp_tlast  = olast_ff;
   assign rsp_tuser  = ostat_ff;

endmodule

// ----- hw/rtl/smcp_divider.sv -----
module smcp_divider
   import smcp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   // restoring divider, one quotient bit per cycle
   logic [63:0] quot_ff, quot_in;
   logic [64:0] rem_ff, rem_in;
   logic [63:0] dsr_ff, dsr_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (div_req.start) begin
         quot_in = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
         cnt_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff[63:0], quot_ff[63]};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in  = trial - {1'b0, dsr_ff};
            quot_in = {quot_ff[62:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule

// ----- hw/rtl/smcp_checker.sv -----
module smcp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic        rsp_tlast,
   input logic [39:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // result held while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
         $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result changed under stall");

   // no loading while results are pending
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input open during output");

   // status code is never the unused value
   a_stat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 2'd3)
      else $error("bad status");

   // last transaction closes input
   a_tlast: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input not closed after last");

endmodule

bind svm_multiplier_constraint_projection_top smcp_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .req_tlast(req_tlast), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tlast(rsp_tlast), .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
);
